>>> rtl/core/atfc_pkg.sv
package atfc_pkg;

    localparam int          QDEPTH   = 4;
    localparam int          QAW      = $clog2(QDEPTH);
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [1:0] TAG_EV  = 2'd0;
    localparam logic [1:0] TAG_AD  = 2'd1;
    localparam logic [1:0] TAG_ST  = 2'd2;
    localparam logic [1:0] TAG_ACK = 2'd3;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // One queued job: the characters that one accepted word produces
    typedef struct packed {
        logic        hdr;
        logic [1:0]  tag;
        logic [7:0]  data;
        logic        pay;
        logic        trl;
        logic [15:0] crc;
    } t_job;

    typedef enum logic [7:0] {
        PH_DOLLAR = 8'b0000_0001,
        PH_TAG    = 8'b0000_0010,
        PH_COMMA  = 8'b0000_0100,
        PH_PAY    = 8'b0000_1000,
        PH_STAR   = 8'b0001_0000,
        PH_HEX    = 8'b0010_0000,
        PH_CR     = 8'b0100_0000,
        PH_LF     = 8'b1000_0000
    } t_phase;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'h0, nib};
        end else begin
            r = 8'h37 + {4'h0, nib};
        end
        return r;
    endfunction

    function automatic logic [1:0] tag_last_idx(input logic [1:0] tag);
        return (tag == TAG_ACK) ? 2'd2 : 2'd1;
    endfunction

    function automatic logic [7:0] tag_char(input logic [1:0] tag, input logic [1:0] idx);
        logic [7:0] r;
        r = 8'h00;
        case (tag)
            TAG_EV: begin
                r = (idx == 2'd0) ? 8'h45 : 8'h56;
            end
            TAG_AD: begin
                r = (idx == 2'd0) ? 8'h41 : 8'h44;
            end
            TAG_ST: begin
                r = (idx == 2'd0) ? 8'h53 : 8'h54;
            end
            TAG_ACK: begin
                case (idx)
                    2'd0:    r = 8'h41;
                    2'd1:    r = 8'h43;
                    default: r = 8'h4B;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/atfc_front.sv
module atfc_front #(
    parameter int MAX_PAYLOAD = 127
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_data,
    input  logic            i_push,
    input  logic            i_q_full,
    input  logic [7:0]      i_payload_byte,
    input  logic            i_first_byte,
    input  logic            i_last_byte,
    input  logic [1:0]      i_tag_code,
    output atfc_pkg::t_job  o_job,
    output logic            o_job_push
);
    import atfc_pkg::*;

    localparam int CW = $clog2(MAX_PAYLOAD + 1);

    logic          r_stream_on;
    logic          r_drop;
    logic [15:0]   r_crc;
    logic [CW-1:0] r_count;

    logic          n_drop;
    logic [15:0]   n_crc;
    logic [CW-1:0] n_count;

    logic          accept;
    logic [15:0]   base_crc;
    logic [CW-1:0] base_cnt;
    logic          pay;
    logic [15:0]   upd_crc;

    always_comb begin
        accept   = i_push & ~i_q_full;
        base_crc = i_first_byte ? CRC_INIT : r_crc;
        base_cnt = i_first_byte ? '0 : r_count;
        n_drop   = i_first_byte ? (~r_stream_on & (i_tag_code == TAG_EV || i_tag_code == TAG_AD))
                                : r_drop;
        pay      = base_cnt < CW'(MAX_PAYLOAD);
        upd_crc  = pay ? crc_byte(base_crc, i_payload_byte) : base_crc;
        if (n_drop) begin
            n_crc   = base_crc;
            n_count = base_cnt;
        end else if (i_last_byte) begin
            n_crc   = CRC_INIT;
            n_count = '0;
        end else begin
            n_crc   = upd_crc;
            n_count = pay ? base_cnt + CW'(1) : base_cnt;
        end
        o_job.hdr  = i_first_byte;
        o_job.tag  = i_tag_code;
        o_job.data = i_payload_byte;
        o_job.pay  = pay;
        o_job.trl  = i_last_byte;
        o_job.crc  = upd_crc;
        // drop words of a suppressed frame and words that emit nothing
        o_job_push = accept & ~n_drop & (i_first_byte | pay | i_last_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_on <= 1'b1;
            r_drop      <= 1'b0;
            r_crc       <= CRC_INIT;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_stream_on <= i_cfg_data;
            end
            if (accept) begin
                r_drop  <= n_drop;
                r_crc   <= n_crc;
                r_count <= n_count;
            end
        end
    end

endmodule

>>> rtl/core/atfc_q.sv
module atfc_q (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  atfc_pkg::t_job  i_job,
    input  logic            i_pop,
    output atfc_pkg::t_job  o_job,
    output logic            o_full,
    output logic            o_empty
);
    import atfc_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (QAW + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (QAW + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (QAW + 1)'(1);
            end
        end
    end

endmodule

>>> rtl/core/atfc_back.sv
module atfc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  atfc_pkg::t_job  i_job,
    input  logic            i_q_empty,
    input  logic            i_out_pop,
    output logic            o_q_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic            o_frame_end,
    output logic            o_run_last
);
    import atfc_pkg::*;

    logic       r_run;
    t_phase     r_ph;
    logic [1:0] r_idx;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_fe;
    logic       r_last;

    t_phase     ph;
    t_phase     start_ph;
    t_phase     n_ph;
    logic [1:0] idx;
    logic [1:0] n_idx;
    logic [7:0] ch;
    logic       fe;
    logic       done;
    logic       adv;
    logic       emit;
    logic [3:0] nib;

    always_comb begin
        adv  = ~r_ov | i_out_pop;
        emit = adv & ~i_q_empty;
        if (i_job.hdr) begin
            start_ph = PH_DOLLAR;
        end else if (i_job.pay) begin
            start_ph = PH_PAY;
        end else begin
            start_ph = PH_STAR;
        end
        ph    = r_run ? r_ph : start_ph;
        idx   = r_run ? r_idx : 2'd0;
        ch    = CH_DOLLAR;
        fe    = 1'b0;
        done  = 1'b0;
        n_ph  = ph;
        n_idx = 2'd0;
        case (idx)
            2'd0:    nib = i_job.crc[15:12];
            2'd1:    nib = i_job.crc[11:8];
            2'd2:    nib = i_job.crc[7:4];
            default: nib = i_job.crc[3:0];
        endcase
        case (ph)
            PH_DOLLAR: begin
                ch   = CH_DOLLAR;
                n_ph = PH_TAG;
            end
            PH_TAG: begin
                ch = tag_char(i_job.tag, idx);
                if (idx == tag_last_idx(i_job.tag)) begin
                    n_ph = PH_COMMA;
                end else begin
                    n_idx = idx + 2'd1;
                end
            end
            PH_COMMA: begin
                ch = CH_COMMA;
                if (i_job.pay) begin
                    n_ph = PH_PAY;
                end else if (i_job.trl) begin
                    n_ph = PH_STAR;
                end else begin
                    done = 1'b1;
                end
            end
            PH_PAY: begin
                ch   = i_job.data;
                n_ph = PH_STAR;
                done = ~i_job.trl;
            end
            PH_STAR: begin
                ch   = CH_STAR;
                n_ph = PH_HEX;
            end
            PH_HEX: begin
                ch = hex_char(nib);
                if (idx == 2'd3) begin
                    n_ph = PH_CR;
                end else begin
                    n_idx = idx + 2'd1;
                end
            end
            PH_CR: begin
                ch   = CH_CR;
                n_ph = PH_LF;
            end
            PH_LF: begin
                ch   = CH_LF;
                fe   = 1'b1;
                done = 1'b1;
            end
            default: begin
                ch   = CH_LF;
                done = 1'b1;
            end
        endcase
        // the job stays at the queue head until its final character leaves
        o_q_pop = emit & done;
    end

    assign o_empty     = ~r_ov;
    assign o_out_byte  = r_byte;
    assign o_frame_end = r_fe;
    assign o_run_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_ph  <= PH_DOLLAR;
            r_idx <= 2'd0;
            r_ov  <= 1'b0;
        end else begin
            if (emit) begin
                r_run <= ~done;
                r_ph  <= n_ph;
                r_idx <= n_idx;
                r_ov  <= 1'b1;
            end else if (i_out_pop) begin
                r_ov  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= ch;
            r_fe   <= fe;
            r_last <= done;
        end
    end

endmodule

>>> rtl/core/ascii_telemetry_framer_crc16_unit.sv
// ASCII telemetry framer with CRC-16/CCITT-FALSE trailer.
// Input side is a queue: present a payload word on the i_ fields with push while
// full is low. first_byte opens a frame with '$', the tag and ','; last_byte
// closes it with '*', four uppercase hex CRC digits of the payload, CR and LF.
// Output side is a queue: while empty is low the oldest character sits on the
// o_ ports; pop takes it. run_last marks the final character of one input word,
// frame_end marks the closing line feed.
// The first character of a word passes through the job queue and the output register.
// Output runs at one character per cycle while the receiver pops, from the
// single output sequencer; a word makes 1 to 13 characters, and words that
// make no character never enter the job queue. A four-entry job queue sits
// between the word classifier and the sequencer, so full rises only when it fills.
// A stalled receiver holds the current character; the sequencer stops and the
// job queue fills behind it. i_cfg_we writes stream_on; with it low, EV and AD
// frames are swallowed. Reset (synchronous, active low) empties both queues,
// sets stream_on, clears the CRC to 0xFFFF and the payload count to zero.
module ascii_telemetry_framer_crc16_unit #(
    parameter int MAX_PAYLOAD = 127
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_payload_byte,
    input  logic       i_first_byte,
    input  logic       i_last_byte,
    input  logic [1:0] i_tag_code,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end,
    output logic       o_run_last
);
    import atfc_pkg::*;

    t_job job_in;
    t_job job_head;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    assign full = q_full;

    atfc_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .i_q_full       (q_full),
        .i_payload_byte (i_payload_byte),
        .i_first_byte   (i_first_byte),
        .i_last_byte    (i_last_byte),
        .i_tag_code     (i_tag_code),
        .o_job          (job_in),
        .o_job_push     (q_push)
    );

    atfc_q u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job_in),
        .i_pop   (q_pop),
        .o_job   (job_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    atfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_head),
        .i_q_empty   (q_empty),
        .i_out_pop   (pop),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end),
        .o_run_last  (o_run_last)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("job pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_empty |-> !q_pop)
        else $error("job popped from an empty queue");

    a_lf_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end) |-> (o_run_last && o_out_byte == CH_LF))
        else $error("frame end not on a line feed closing the run");
`endif

endmodule

>>> dv/ascii_telemetry_framer_crc16_unit_test.sv
module ascii_telemetry_framer_crc16_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import atfc_pkg::*;

    localparam int PAYLOAD_CAP    = 127;
    localparam int PLAN_LEN       = 23;
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 35;
    localparam int SETTLE_CYCLES  = 12;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic [7:0] pb;
        logic       first;
        logic       last;
        logic [1:0] tag;
    } t_word;

    typedef struct packed {
        logic [7:0] ch;
        logic       fend;
        logic       rlast;
    } t_char;

    typedef enum logic [1:0] {
        CFG_KEEP,
        CFG_OFF,
        CFG_ON
    } t_cfg_op;

    // typed = 1: the row carries its own answer, none or one bare payload char
    typedef struct packed {
        t_cfg_op    op;
        logic [7:0] pb;
        logic       first;
        logic       last;
        logic [1:0] tag;
        logic       typed;
        logic       n_one;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_data = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_payload_byte = 8'h00;
    logic       i_first_byte = 1'b0;
    logic       i_last_byte = 1'b0;
    logic [1:0] i_tag_code = TAG_EV;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_frame_end;
    logic       o_run_last;

    ascii_telemetry_framer_crc16_unit #(
        .MAX_PAYLOAD(PAYLOAD_CAP)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_payload_byte(i_payload_byte),
        .i_first_byte  (i_first_byte),
        .i_last_byte   (i_last_byte),
        .i_tag_code    (i_tag_code),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_frame_end   (o_frame_end),
        .o_run_last    (o_run_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // framer state as seen from outside
    logic        stream_en  = 1'b1;
    logic [15:0] frame_crc  = CRC_INIT;
    logic        frame_drop = 1'b0;
    logic [7:0]  frame_len  = 8'd0;

    t_char framed_q[$];
    t_char run_q[$];
    int    fail_cnt     = 0;
    int    words_framed = 0;
    int    hold_req     = 0;
    int    burst_left   = 0;
    bit    calm         = 1'b0;

    t_row plan [PLAN_LEN] = '{
        '{CFG_KEEP, 8'h00, 1'b0, 1'b0, TAG_EV,  1'b1, 1'b1},
        '{CFG_KEEP, 8'hFF, 1'b0, 1'b0, TAG_EV,  1'b1, 1'b1},
        '{CFG_KEEP, 8'h41, 1'b0, 1'b1, TAG_ACK, 1'b0, 1'b0},
        '{CFG_KEEP, 8'h41, 1'b1, 1'b0, TAG_EV,  1'b0, 1'b0},
        '{CFG_KEEP, 8'h5A, 1'b0, 1'b0, TAG_EV,  1'b0, 1'b0},
        '{CFG_KEEP, 8'h30, 1'b0, 1'b1, TAG_EV,  1'b0, 1'b0},
        '{CFG_KEEP, 8'h80, 1'b1, 1'b0, TAG_AD,  1'b0, 1'b0},
        '{CFG_KEEP, 8'h00, 1'b1, 1'b0, TAG_ST,  1'b0, 1'b0},
        '{CFG_KEEP, 8'hFF, 1'b0, 1'b1, TAG_ST,  1'b0, 1'b0},
        '{CFG_KEEP, 8'h31, 1'b1, 1'b1, TAG_ACK, 1'b0, 1'b0},
        '{CFG_KEEP, 8'h7F, 1'b1, 1'b1, TAG_ST,  1'b0, 1'b0},
        '{CFG_OFF,  8'h11, 1'b1, 1'b0, TAG_EV,  1'b1, 1'b0},
        '{CFG_KEEP, 8'h22, 1'b0, 1'b0, TAG_ST,  1'b1, 1'b0},
        '{CFG_KEEP, 8'h33, 1'b0, 1'b1, TAG_EV,  1'b1, 1'b0},
        '{CFG_KEEP, 8'h44, 1'b1, 1'b1, TAG_AD,  1'b1, 1'b0},
        '{CFG_KEEP, 8'h55, 1'b1, 1'b0, TAG_ST,  1'b0, 1'b0},
        '{CFG_KEEP, 8'h66, 1'b0, 1'b1, TAG_AD,  1'b0, 1'b0},
        '{CFG_KEEP, 8'h77, 1'b1, 1'b1, TAG_ACK, 1'b0, 1'b0},
        '{CFG_KEEP, 8'h01, 1'b0, 1'b0, TAG_EV,  1'b1, 1'b1},
        '{CFG_ON,   8'h88, 1'b1, 1'b1, TAG_EV,  1'b0, 1'b0},
        '{CFG_KEEP, 8'hAA, 1'b1, 1'b0, TAG_AD,  1'b0, 1'b0},
        '{CFG_KEEP, 8'hBB, 1'b1, 1'b1, TAG_EV,  1'b0, 1'b0},
        '{CFG_KEEP, 8'hFE, 1'b0, 1'b1, TAG_ACK, 1'b0, 1'b0}
    };

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // shift in one data bit per step, MSB first
    function automatic logic [15:0] crc_shift(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void put_char(input logic [7:0] ch, input logic fend);
        run_q.push_back('{ch, fend, 1'b0});
    endfunction

    // fill run_q with the characters one accepted word yields
    function automatic void frame_word(input t_word w);
        string tag_txt;
        string hex_txt;
        hex_txt = "0123456789ABCDEF";
        run_q.delete();
        if (w.first) begin
            frame_drop = !stream_en && (w.tag == TAG_EV || w.tag == TAG_AD);
            frame_crc  = CRC_INIT;
            frame_len  = 8'd0;
        end
        if (frame_drop) begin
            return;
        end
        if (w.first) begin
            case (w.tag)
                TAG_EV:  tag_txt = "EV";
                TAG_AD:  tag_txt = "AD";
                TAG_ST:  tag_txt = "ST";
                default: tag_txt = "ACK";
            endcase
            put_char(CH_DOLLAR, 1'b0);
            for (int i = 0; i < tag_txt.len(); i++) begin
                put_char(tag_txt[i], 1'b0);
            end
            put_char(CH_COMMA, 1'b0);
        end
        // drop payload past the cap, but still close the frame
        if (frame_len < PAYLOAD_CAP) begin
            put_char(w.pb, 1'b0);
            frame_crc = crc_shift(frame_crc, w.pb);
            frame_len = frame_len + 8'd1;
        end
        if (w.last) begin
            put_char(CH_STAR, 1'b0);
            for (int k = 3; k >= 0; k--) begin
                put_char(hex_txt[frame_crc[4*k +: 4]], 1'b0);
            end
            put_char(CH_CR, 1'b0);
            put_char(CH_LF, 1'b1);
            frame_crc = CRC_INIT;
            frame_len = 8'd0;
        end
        if (run_q.size() > 0) begin
            run_q[run_q.size() - 1].rlast = 1'b1;
        end
    endfunction

    function automatic void report_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) begin
            $display("%s", msg);
        end
    endfunction

    task automatic send_word(input t_word w, input logic typed, input logic n_one);
        int gap;
        gap = (burst_left > 0) ? 0 : pick_gap();
        if (burst_left > 0) begin
            burst_left--;
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_payload_byte <= w.pb;
        i_first_byte   <= w.first;
        i_last_byte    <= w.last;
        i_tag_code     <= w.tag;
        do @(posedge i_clk); while (full);
        frame_word(w);
        if (typed) begin
            run_q.delete();
            if (n_one) begin
                run_q.push_back('{w.pb, 1'b0, 1'b1});
            end
        end
        if (run_q.size() > 0) begin
            words_framed++;
        end
        foreach (run_q[i]) begin
            framed_q.push_back(run_q[i]);
        end
    endtask

    // write stream_on only once the block has gone quiet
    task automatic set_stream(input logic v);
        push <= 1'b0;
        @(posedge i_clk);
        while (framed_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        stream_en = v;
    endtask

    task automatic gen_frame(input bit long_one);
        int    r;
        int    len;
        t_word w;
        r = long_one ? 0 : $urandom_range(0, 99);
        if (r < 80) begin
            if (long_one) begin
                len = $urandom_range(PAYLOAD_CAP + 1, PAYLOAD_CAP + 4);
            end else if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(13, 30);
            end else begin
                len = $urandom_range(1, 8);
            end
            for (int k = 0; k < len; k++) begin
                w.pb    = 8'($urandom);
                w.first = (k == 0);
                w.last  = (k == len - 1);
                w.tag   = 2'($urandom);
                send_word(w, 1'b0, 1'b0);
            end
        end else if (r < 90) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
                w = t_word'(12'($urandom));
                send_word(w, 1'b0, 1'b0);
            end
        end else begin
            // open a frame and never close it
            len = $urandom_range(1, 5);
            for (int k = 0; k < len; k++) begin
                w.pb    = 8'($urandom);
                w.first = (k == 0);
                w.last  = 1'b0;
                w.tag   = 2'($urandom);
                send_word(w, 1'b0, 1'b0);
            end
        end
    endtask

    // result side: check each popped character, then pick the next pop gap
    initial begin
        t_char want;
        int    pop_wait;
        int    hold_cnt;
        pop_wait = 0;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (framed_q.size() == 0) begin
                    report_fail($sformatf("unexpected char %02h end=%0b last=%0b",
                        o_out_byte, o_frame_end, o_run_last));
                end else begin
                    want = framed_q.pop_front();
                    if (o_out_byte !== want.ch || o_frame_end !== want.fend ||
                        o_run_last !== want.rlast) begin
                        report_fail($sformatf(
                            "mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                            want.ch, want.fend, want.rlast,
                            o_out_byte, o_frame_end, o_run_last));
                    end
                end
                pop_wait = pick_gap();
            end
            if (hold_req > 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt--;
                pop <= 1'b0;
            end else if (pop_wait > 0) begin
                pop_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // end the run once no word or character moves on either side for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_word w;
        int    base;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < PLAN_LEN; r++) begin
            if (plan[r].op == CFG_OFF) begin
                set_stream(1'b0);
            end else if (plan[r].op == CFG_ON) begin
                set_stream(1'b1);
            end
            w.pb    = plan[r].pb;
            w.first = plan[r].first;
            w.last  = plan[r].last;
            w.tag   = plan[r].tag;
            send_word(w, plan[r].typed, plan[r].n_one);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            set_stream((ph % 2) == 0);
            calm = (ph == 4);
            if (ph == 2) begin
                // stall the receiver while the sender keeps pushing
                hold_req   = 300;
                burst_left = 40;
            end
            base = words_framed;
            if (ph == 0) begin
                gen_frame(1'b1);
            end
            while (words_framed - base < PHASE_WORDS) begin
                gen_frame(1'b0);
            end
        end
        calm = 1'b0;

        push <= 1'b0;
        @(posedge i_clk);
        while (framed_q.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
